// ----- src/e2r_pkg.sv -----
// shared types and constants for the euler angle rotation matrix block
package e2r_pkg;

   localparam int PHASE_WIDTH  = 32;
   localparam int INNER_WIDTH  = 34;
   localparam int CORDIC_STEPS = 24;
   localparam int INNER_FRAC   = 30;
   localparam int ANGLE_FRAC   = 16;

   localparam logic [29:0] DEG_TO_PHASE = 30'd11930465;
   localparam logic [29:0] RAD_TO_PHASE = 30'd683565276;
   localparam logic signed [INNER_WIDTH-1:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [INNER_WIDTH-1:0] ONE_Q30 = 34'sd1073741824;

   localparam logic OP_ZXY = 1'b0;
   localparam logic OP_ZYZ = 1'b1;

   typedef logic signed [INNER_WIDTH-1:0] inner_type;

   typedef struct packed {
      inner_type c;
      inner_type s;
   } sincos_type;

   function automatic logic signed [PHASE_WIDTH:0] atan_turn(input logic [4:0] i);
      logic signed [PHASE_WIDTH:0] r;
      begin
         case (i)
            5'd0:  r = 33'sd536870912;
            5'd1:  r = 33'sd316933406;
            5'd2:  r = 33'sd167458907;
            5'd3:  r = 33'sd85004756;
            5'd4:  r = 33'sd42667331;
            5'd5:  r = 33'sd21354465;
            5'd6:  r = 33'sd10679838;
            5'd7:  r = 33'sd5340245;
            5'd8:  r = 33'sd2670163;
            5'd9:  r = 33'sd1335086;
            5'd10: r = 33'sd667544;
            5'd11: r = 33'sd333772;
            5'd12: r = 33'sd166886;
            5'd13: r = 33'sd83443;
            5'd14: r = 33'sd41722;
            5'd15: r = 33'sd20861;
            5'd16: r = 33'sd10430;
            5'd17: r = 33'sd5215;
            5'd18: r = 33'sd2608;
            5'd19: r = 33'sd1304;
            5'd20: r = 33'sd652;
            5'd21: r = 33'sd326;
            5'd22: r = 33'sd163;
            5'd23: r = 33'sd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- src/e2r_lane.sv -----
// one angle lane: phase conversion and pipelined cordic sine and cosine
module e2r_lane #(
   parameter int ANGLE_WIDTH = 26
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic                                radians,
   input  logic signed [ANGLE_WIDTH-1:0]       angle,
   output e2r_pkg::sincos_type                 result
);
   localparam int PW = e2r_pkg::PHASE_WIDTH;
   localparam int PRODW = ANGLE_WIDTH + 31;
   localparam int N = e2r_pkg::CORDIC_STEPS;

   logic signed [PRODW-1:0] prod_ff, prod_in;
   logic [PW-1:0] phase;
   logic flip;
   logic [PW-1:0] ph_adj;

   e2r_pkg::inner_type x_ff [N+1];
   e2r_pkg::inner_type y_ff [N+1];
   logic signed [PW:0]  z_ff [N+1];
   logic                flip_ff [N+1];

   always_comb begin
      prod_in = PRODW'(angle) * $signed({1'b0, (radians ? e2r_pkg::RAD_TO_PHASE
                                                         : e2r_pkg::DEG_TO_PHASE)});
   end

   always_ff @(posedge clock) begin
      if (en) prod_ff <= prod_in;
   end

   always_comb begin
      phase  = PW'((prod_ff + PRODW'(1 << (e2r_pkg::ANGLE_FRAC - 1))) >>> e2r_pkg::ANGLE_FRAC);
      flip   = phase[PW-1] ^ phase[PW-2];
      ph_adj = flip ? (phase ^ {1'b1, {(PW-1){1'b0}}}) : phase;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= e2r_pkg::CORDIC_START;
         y_ff[0]    <= '0;
         z_ff[0]    <= $signed({ph_adj[PW-1], ph_adj});
         flip_ff[0] <= flip;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      e2r_pkg::inner_type dx;
      assign dx = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!z_ff[i][PW]) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + dx;
               z_ff[i+1] <= z_ff[i] - e2r_pkg::atan_turn(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - dx;
               z_ff[i+1] <= z_ff[i] + e2r_pkg::atan_turn(5'(i));
            end
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign result.c = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign result.s = flip_ff[N] ? -y_ff[N] : y_ff[N];
endmodule

// ----- src/e2r_merge.sv -----
// merging stages: two 3x3 products and rounding to output elements
module e2r_merge #(
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic                                 op,
   input  e2r_pkg::sincos_type                  sc0,
   input  e2r_pkg::sincos_type                  sc1,
   input  e2r_pkg::sincos_type                  sc2,
   output logic [9*ELEMENT_WIDTH-1:0]           elems
);
   localparam int IW = e2r_pkg::INNER_WIDTH;
   localparam int AW = 2 * IW + 2;
   localparam int SH = e2r_pkg::INNER_FRAC + 1 - ELEMENT_WIDTH;

   typedef e2r_pkg::inner_type mat_type [9];

   mat_type a, b, c_in;
   mat_type c2_ff, t_ff, t_calc, m_calc, m_ff;

   function automatic void axis_mat(input logic [1:0] ax, input e2r_pkg::sincos_type sc,
                                    output mat_type m);
      begin
         for (int k = 0; k < 9; k++) m[k] = '0;
         case (ax)
            2'd0: begin
               m[0] = e2r_pkg::ONE_Q30; m[4] = sc.c; m[5] = -sc.s; m[7] = sc.s; m[8] = sc.c;
            end
            2'd1: begin
               m[0] = sc.c; m[2] = sc.s; m[4] = e2r_pkg::ONE_Q30; m[6] = -sc.s; m[8] = sc.c;
            end
            default: begin
               m[0] = sc.c; m[1] = -sc.s; m[3] = sc.s; m[4] = sc.c; m[8] = e2r_pkg::ONE_Q30;
            end
         endcase
      end
   endfunction

   function automatic e2r_pkg::inner_type dot3(input e2r_pkg::inner_type p0,
      input e2r_pkg::inner_type q0, input e2r_pkg::inner_type p1,
      input e2r_pkg::inner_type q1, input e2r_pkg::inner_type p2,
      input e2r_pkg::inner_type q2);
      logic signed [AW-1:0] acc;
      begin
         acc = AW'(p0) * AW'(q0) + AW'(p1) * AW'(q1) + AW'(p2) * AW'(q2)
             + AW'(64'sd1 <<< (e2r_pkg::INNER_FRAC - 1));
         return IW'(acc >>> e2r_pkg::INNER_FRAC);
      end
   endfunction

   always_comb begin
      axis_mat(2'd2, sc0, a);
      axis_mat((op == e2r_pkg::OP_ZYZ) ? 2'd1 : 2'd0, sc1, b);
      axis_mat((op == e2r_pkg::OP_ZYZ) ? 2'd2 : 2'd1, sc2, c_in);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            t_calc[i*3+j] = dot3(a[i*3], b[j], a[i*3+1], b[3+j], a[i*3+2], b[6+j]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff  <= t_calc;
         c2_ff <= c_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            m_calc[i*3+j] = dot3(t_ff[i*3], c2_ff[j], t_ff[i*3+1], c2_ff[3+j],
                                 t_ff[i*3+2], c2_ff[6+j]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff <= m_calc;
      end
   end

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         logic signed [IW:0] r;
         logic signed [IW:0] hi, lo;
         hi = (IW+1)'((64'sd1 <<< (ELEMENT_WIDTH - 1)) - 1);
         lo = -(IW+1)'(64'sd1 <<< (ELEMENT_WIDTH - 1));
         if (SH > 0)
            r = ((IW+1)'(m_ff[k]) + (IW+1)'(64'sd1 <<< ((SH > 0) ? SH - 1 : 0))) >>> SH;
         else
            r = (IW+1)'(m_ff[k]) <<< ((SH > 0) ? 0 : -SH);
         if (r > hi) r = hi;
         if (r < lo) r = lo;
         elems[k*ELEMENT_WIDTH +: ELEMENT_WIDTH] = r[ELEMENT_WIDTH-1:0];
      end
   end
endmodule

// ----- src/euler_to_rotation_matrix.sv -----
// top level: euler angles to 3x3 rotation matrix, streaming
// req to rsp valid passes the multiply, cordic start, cordic and two product registers
// throughput: one transaction per cycle; pipeline stalls as a whole on rsp back-pressure
// each of three angle lanes holds the multiply and a 24-stage cordic
// reset: synchronous active high, clears valid pipeline and unit register (degrees)
module euler_to_rotation_matrix #(
   parameter int ANGLE_WIDTH   = 26,
   parameter int ELEMENT_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // angle_first, angle_second, angle_third, zero fill
   input  logic [((3*ANGLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   // opcode
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // m00 m01 m02 m10 m11 m12 m20 m21 m22, zero fill
   output logic [((9*ELEMENT_WIDTH+7)/8)*8-1:0]  rsp_tdata
);
   localparam int LAT = e2r_pkg::CORDIC_STEPS + 4;
   localparam int OW  = ((9*ELEMENT_WIDTH+7)/8)*8;

   logic radians_ff;
   logic [LAT-1:0] vld_ff;
   logic [LAT-3:0] op_ff;
   logic en;
   e2r_pkg::sincos_type sc [3];
   logic [9*ELEMENT_WIDTH-1:0] elems;

   assign en         = rsp_tready || !vld_ff[LAT-1];
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = OW'(elems);

   always_ff @(posedge clock) begin
      if (reset) begin
         radians_ff <= 1'b0;
         vld_ff     <= '0;
      end else begin
         if (csr_valid) radians_ff <= csr_data;
         if (en) vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) op_ff <= {op_ff[LAT-4:0], req_tuser};
   end

   for (genvar g = 0; g < 3; g++) begin : g_lane
      e2r_lane #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_lane (
         .clock   (clock),
         .en      (en),
         .radians (radians_ff),
         .angle   ($signed(req_tdata[g*ANGLE_WIDTH +: ANGLE_WIDTH])),
         .result  (sc[g])
      );
   end

   e2r_merge #(.ELEMENT_WIDTH(ELEMENT_WIDTH)) u_merge (
      .clock (clock),
      .en    (en),
      .op    (op_ff[LAT-3]),
      .sc0   (sc[0]),
      .sc1   (sc[1]),
      .sc2   (sc[2]),
      .elems (elems)
   );

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("stalled with empty output");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_valid |=> radians_ff == $past(csr_data))
      else $error("unit register not written");
endmodule
